// ----- rtl/core/pswrl_pkg.sv -----
// ----------------------------------------------------------------------------
// pswrl_pkg
// Shared types and constants of the per-source window rate limiter.
// ----------------------------------------------------------------------------
package pswrl_pkg;

	localparam int TABLE_ENTRIES = 128;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_WINDOW = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_LIMIT  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WINDOW = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LIMIT  = CFG_IDX_W'(3);

	localparam logic [31:0] GLOBAL_WINDOW_RST = 32'd1000;
	localparam logic [7:0]  GLOBAL_LIMIT_RST  = 8'd8;
	localparam logic [31:0] SOURCE_WINDOW_RST = 32'd60000;
	localparam logic [7:0]  SOURCE_LIMIT_RST  = 8'd4;

	typedef enum logic [1:0] {
		ST_ALLOWED = 2'd0,
		ST_GLOBAL  = 2'd1,
		ST_FULL    = 2'd2,
		ST_SOURCE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GLOBAL,
		S_SCAN,
		S_UPDATE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [63:0] start;
		logic [7:0]  count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// time running backwards also counts as expired
	function automatic logic expired(input logic [63:0] now, input logic [63:0] start,
			input logic [31:0] len);
		logic [63:0] diff;
		diff = now - start;
		return (now < start) || (diff >= {32'd0, len});
	endfunction

endpackage

// ----- rtl/core/per_source_window_rate_limiter_unit.sv -----
// ----------------------------------------------------------------------------
// per_source_window_rate_limiter_unit
// Fixed-window rate limiter with a global window and a table of per-key
// windows held in one RAM, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// path: a request goes S_GLOBAL then S_DONE when the global limit denies,
// otherwise S_GLOBAL, S_SCAN, S_UPDATE, S_DONE (scan stops early on a key match)
// requests: a new one is accepted only in S_IDLE, once the last result has left
// S_DONE; the scan runs sequentially over the single read port of the entry RAM
// reset: config registers take their defaults, global window and all entry
// valid bits clear at once; no clearing pass is needed
module per_source_window_rate_limiter_unit (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [63:0]                         now,
	input  logic [63:0]                         key_high,
	input  logic [63:0]                         key_low,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                allowed,
	output logic [1:0]                          status,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pswrl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pswrl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int N = pswrl_pkg::TABLE_ENTRIES;
	localparam int IW = pswrl_pkg::IDX_W;

	// configuration
	logic [31:0] global_window_q;
	logic [7:0]  global_limit_q;
	logic [31:0] source_window_q;
	logic [7:0]  source_limit_q;

	// control and state
	pswrl_pkg::state_t  state_q, state_d;
	pswrl_pkg::status_t status_q, res_status_q;
	logic               out_valid_q;
	logic [63:0]        global_start_q;
	logic [7:0]         global_count_q;
	logic [N-1:0]       valid_q;

	// request and scan results
	logic [63:0]   now_q, kh_q, kl_q;
	logic [IW-1:0] scan_idx_q;
	logic          found_q, have_free_q, hit_exp_q;
	logic [IW-1:0] free_idx_q, hit_idx_q;
	logic [63:0]   hit_start_q;
	logic [7:0]    hit_count_q;

	// ram
	logic                          ram_we;
	logic [IW-1:0]                 ram_waddr, ram_raddr;
	pswrl_pkg::entry_t             ram_wdata, rd_entry;
	logic [pswrl_pkg::ENTRY_W-1:0] ram_rdata;

	// combinational
	logic          in_fire;
	logic          g_restart, g_deny;
	logic [7:0]    g_eff;
	logic          ent_valid, key_match, ent_exp, is_free, scan_last;
	logic          can_claim, src_deny;
	logic [IW-1:0] upd_idx;
	logic [63:0]   cur_start;
	logic [7:0]    cur_count;
	logic          out_slot;

	assign in_ready  = (state_q == pswrl_pkg::S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign allowed   = (status_q == pswrl_pkg::ST_ALLOWED);
	assign out_slot  = !out_valid_q || out_ready;

	assign rd_entry = pswrl_pkg::entry_t'(ram_rdata);

	// global window check
	assign g_restart = (global_count_q == 8'd0) ||
		pswrl_pkg::expired(now_q, global_start_q, global_window_q);
	assign g_eff  = g_restart ? 8'd0 : global_count_q;
	assign g_deny = (g_eff >= global_limit_q);

	// scan compare on the entry read last cycle
	assign ent_valid = valid_q[scan_idx_q];
	assign key_match = ent_valid && (rd_entry.key_high == kh_q) && (rd_entry.key_low == kl_q);
	assign ent_exp   = pswrl_pkg::expired(now_q, rd_entry.start, source_window_q);
	assign is_free   = !ent_valid || ent_exp;
	assign scan_last = (scan_idx_q == IW'(N - 1));

	// update of the matched or claimed entry
	assign can_claim = found_q || have_free_q;
	assign upd_idx   = found_q ? hit_idx_q : free_idx_q;
	assign cur_start = (!found_q || hit_exp_q) ? now_q : hit_start_q;
	assign cur_count = (!found_q || hit_exp_q) ? 8'd0 : hit_count_q;
	assign src_deny  = (cur_count >= source_limit_q);

	assign ram_raddr = (state_q == pswrl_pkg::S_GLOBAL) ? '0 : IW'(scan_idx_q + 1'b1);
	assign ram_waddr = upd_idx;
	assign ram_we    = (state_q == pswrl_pkg::S_UPDATE) && can_claim;

	always_comb begin
		ram_wdata.key_high = kh_q;
		ram_wdata.key_low  = kl_q;
		ram_wdata.start    = cur_start;
		ram_wdata.count    = src_deny ? cur_count : cur_count + 8'd1;
	end

	pswrl_ram #(
		.WIDTH(pswrl_pkg::ENTRY_W),
		.DEPTH(N)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pswrl_pkg::S_IDLE: begin
				if (in_fire) begin
					state_d = pswrl_pkg::S_GLOBAL;
				end
			end
			pswrl_pkg::S_GLOBAL: begin
				state_d = g_deny ? pswrl_pkg::S_DONE : pswrl_pkg::S_SCAN;
			end
			pswrl_pkg::S_SCAN: begin
				if (key_match || scan_last) begin
					state_d = pswrl_pkg::S_UPDATE;
				end
			end
			pswrl_pkg::S_UPDATE: begin
				state_d = pswrl_pkg::S_DONE;
			end
			pswrl_pkg::S_DONE: begin
				if (out_slot) begin
					state_d = pswrl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pswrl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pswrl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_window_q <= pswrl_pkg::GLOBAL_WINDOW_RST;
			global_limit_q  <= pswrl_pkg::GLOBAL_LIMIT_RST;
			source_window_q <= pswrl_pkg::SOURCE_WINDOW_RST;
			source_limit_q  <= pswrl_pkg::SOURCE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == pswrl_pkg::CFG_GLOBAL_WINDOW) begin
				global_window_q <= cfg_data[31:0];
			end
			if (cfg_index == pswrl_pkg::CFG_GLOBAL_LIMIT) begin
				global_limit_q <= cfg_data[7:0];
			end
			if (cfg_index == pswrl_pkg::CFG_SOURCE_WINDOW) begin
				source_window_q <= cfg_data[31:0];
			end
			if (cfg_index == pswrl_pkg::CFG_SOURCE_LIMIT) begin
				source_limit_q <= cfg_data[7:0];
			end
		end
	end

	// global window and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_start_q <= '0;
			global_count_q <= '0;
			valid_q        <= '0;
		end else begin
			if (state_q == pswrl_pkg::S_GLOBAL && g_restart) begin
				global_start_q <= now_q;
				global_count_q <= '0;
			end
			if (state_q == pswrl_pkg::S_UPDATE && can_claim) begin
				valid_q[upd_idx] <= 1'b1;
				if (!src_deny) begin
					global_count_q <= global_count_q + 8'd1;
				end
			end
		end
	end

	// request capture and scan bookkeeping
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q <= now;
			kh_q  <= key_high;
			kl_q  <= key_low;
		end
		if (state_q == pswrl_pkg::S_GLOBAL) begin
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			have_free_q  <= 1'b0;
			res_status_q <= pswrl_pkg::ST_GLOBAL;
		end
		if (state_q == pswrl_pkg::S_SCAN) begin
			scan_idx_q <= IW'(scan_idx_q + 1'b1);
			if (key_match) begin
				found_q     <= 1'b1;
				hit_idx_q   <= scan_idx_q;
				hit_start_q <= rd_entry.start;
				hit_count_q <= rd_entry.count;
				hit_exp_q   <= ent_exp;
			end else if (!have_free_q && is_free) begin
				have_free_q <= 1'b1;
				free_idx_q  <= scan_idx_q;
			end
		end
		if (state_q == pswrl_pkg::S_UPDATE) begin
			if (!can_claim) begin
				res_status_q <= pswrl_pkg::ST_FULL;
			end else if (src_deny) begin
				res_status_q <= pswrl_pkg::ST_SOURCE;
			end else begin
				res_status_q <= pswrl_pkg::ST_ALLOWED;
			end
		end
	end

	// result register, one beat per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= pswrl_pkg::ST_ALLOWED;
		end else begin
			if (state_q == pswrl_pkg::S_DONE && out_slot) begin
				out_valid_q <= 1'b1;
				status_q    <= res_status_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/pswrl_ram.sv -----
// ----------------------------------------------------------------------------
// pswrl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pswrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- dv/per_source_window_rate_limiter_unit_test.sv -----
// ----------------------------------------------------------------------------
// per_source_window_rate_limiter_unit_test
// Self-checking bench for the rate limiter: a table of directed requests, then
// phases of random traffic under several limit settings. Every admit/deny
// answer is predicted in-bench and compared beat by beat with the block.
// ----------------------------------------------------------------------------
module per_source_window_rate_limiter_unit_test;

	localparam int RUN_LIMIT   = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PROBES    = 17;
	localparam int N_PHASES    = 6;
	localparam int POOL_MAX    = 256;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIXED_HI = 64'h0123_4567_89AB_CDEF;
	localparam logic [63:0] MIXED_LO = 64'hFEDC_BA98_7654_3210;
	localparam logic [63:0] HALF_BIT = 64'h8000_0000_0000_0000;

	typedef logic [pswrl_pkg::CFG_IDX_W-1:0] cfg_idx_t;

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_ready;
	logic [63:0]                      now       = '0;
	logic [63:0]                      key_high  = '0;
	logic [63:0]                      key_low   = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             allowed;
	logic [1:0]                       status;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	cfg_idx_t                         cfg_index = '0;
	logic [pswrl_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	per_source_window_rate_limiter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.now       (now),
		.key_high  (key_high),
		.key_low   (key_low),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.allowed   (allowed),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	typedef struct packed {
		logic               allowed;
		pswrl_pkg::status_t status;
	} verdict_t;

	typedef struct packed {
		logic [63:0]        t;
		logic [63:0]        kh;
		logic [63:0]        kl;
		logic               typed;
		pswrl_pkg::status_t want;
	} probe_t;

	typedef struct packed {
		logic [31:0] gw;
		logic [7:0]  gl;
		logic [31:0] sw;
		logic [7:0]  sl;
		logic [15:0] items;
		logic [8:0]  pool;
		logic [31:0] step;
		logic        sweep;
		logic        jitter;
		logic        squeeze;
	} phase_t;

	// requests under the reset settings; typed rows carry an obvious answer
	probe_t probe_rows [N_PROBES] = '{
		'{64'd0,      64'd0,    64'd0,    1'b1, pswrl_pkg::ST_ALLOWED},
		'{64'd0,      64'd0,    64'd0,    1'b0, pswrl_pkg::ST_ALLOWED},
		'{64'd0,      64'd0,    64'd0,    1'b0, pswrl_pkg::ST_ALLOWED},
		'{64'd0,      64'd0,    64'd0,    1'b0, pswrl_pkg::ST_ALLOWED},
		'{64'd0,      64'd0,    64'd0,    1'b1, pswrl_pkg::ST_SOURCE},
		'{64'd0,      ALL_ONES, ALL_ONES, 1'b1, pswrl_pkg::ST_ALLOWED},
		'{64'd10,     ALL_ONES, 64'd0,    1'b0, pswrl_pkg::ST_ALLOWED},
		'{64'd20,     64'd0,    ALL_ONES, 1'b0, pswrl_pkg::ST_ALLOWED},
		'{64'd30,     MIXED_HI, MIXED_LO, 1'b0, pswrl_pkg::ST_ALLOWED},
		'{64'd40,     MIXED_LO, MIXED_HI, 1'b1, pswrl_pkg::ST_GLOBAL},
		// global window over, key still at its limit
		'{64'd1000,   64'd0,    64'd0,    1'b0, pswrl_pkg::ST_ALLOWED},
		// key window over
		'{64'd60000,  64'd0,    64'd0,    1'b0, pswrl_pkg::ST_ALLOWED},
		// time running backwards restarts both windows
		'{64'd5,      64'd0,    64'd0,    1'b0, pswrl_pkg::ST_ALLOWED},
		'{ALL_ONES,   ALL_ONES, ALL_ONES, 1'b0, pswrl_pkg::ST_ALLOWED},
		// new key takes over the first lapsed entry
		'{ALL_ONES,   MIXED_HI, 64'd1,    1'b0, pswrl_pkg::ST_ALLOWED},
		'{ALL_ONES,   64'd0,    64'd0,    1'b0, pswrl_pkg::ST_ALLOWED},
		'{HALF_BIT,   64'd7,    HALF_BIT, 1'b0, pswrl_pkg::ST_ALLOWED}
	};

	phase_t phase_plan [N_PHASES] = '{
		'{32'd1000,     8'd8,   32'd60000,    8'd4,   16'd80,  9'd12,  32'd400, 1'b0, 1'b1, 1'b0},
		// long windows, many keys in turn: the table fills up
		'{32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 8'd255, 16'd150, 9'd160, 32'd3,   1'b1, 1'b1, 1'b0},
		'{32'd1,        8'd1,   32'd1,        8'd1,   16'd60,  9'd6,   32'd2,   1'b0, 1'b1, 1'b0},
		// zero windows always lapse, zero key limit denies after the claim
		'{32'd0,        8'd3,   32'd0,        8'd0,   16'd25,  9'd6,   32'd5,   1'b0, 1'b0, 1'b0},
		'{32'd500,      8'd0,   32'd300,      8'd2,   16'd20,  9'd4,   32'd50,  1'b0, 1'b1, 1'b0},
		'{32'd5000,     8'd255, 32'd800,      8'd3,   16'd120, 9'd20,  32'd100, 1'b0, 1'b1, 1'b1}
	};

	// bench copy of the limiter state
	logic [31:0] gwin;
	logic [7:0]  glim;
	logic [31:0] swin;
	logic [7:0]  slim;
	logic [63:0] g_start;
	logic [7:0]  g_count;
	logic        slot_used  [pswrl_pkg::TABLE_ENTRIES];
	logic [63:0] slot_kh    [pswrl_pkg::TABLE_ENTRIES];
	logic [63:0] slot_kl    [pswrl_pkg::TABLE_ENTRIES];
	logic [63:0] slot_start [pswrl_pkg::TABLE_ENTRIES];
	logic [7:0]  slot_count [pswrl_pkg::TABLE_ENTRIES];

	verdict_t    pending_verdicts [$];
	logic [63:0] pool_hi [POOL_MAX];
	logic [63:0] pool_lo [POOL_MAX];
	logic [63:0] t_cursor;
	int          errors;
	int          cycles;
	bit          jitter_on;
	bit          rx_hold;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic lapsed(input logic [63:0] t, input logic [63:0] s,
			input logic [31:0] len);
		return (t < s) || ((t - s) >= {32'd0, len});
	endfunction

	function automatic pswrl_pkg::status_t judge_request(input logic [63:0] t,
			input logic [63:0] kh, input logic [63:0] kl);
		int  i;
		int  hit;
		int  spare;
		bit  found;
		bit  have_spare;
		hit = 0;
		spare = 0;
		found = 1'b0;
		have_spare = 1'b0;
		if (g_count == 8'd0 || lapsed(t, g_start, gwin)) begin
			g_start = t;
			g_count = 8'd0;
		end
		if (g_count >= glim)
			return pswrl_pkg::ST_GLOBAL;
		for (i = 0; i < pswrl_pkg::TABLE_ENTRIES && !found; i++) begin
			if (slot_used[i] && slot_kh[i] == kh && slot_kl[i] == kl) begin
				hit = i;
				found = 1'b1;
			end else if (!have_spare && (!slot_used[i] || lapsed(t, slot_start[i], swin))) begin
				spare = i;
				have_spare = 1'b1;
			end
		end
		if (!found) begin
			if (!have_spare)
				return pswrl_pkg::ST_FULL;
			hit = spare;
			slot_used[hit] = 1'b1;
			slot_kh[hit] = kh;
			slot_kl[hit] = kl;
			slot_start[hit] = t;
			slot_count[hit] = 8'd0;
		end else if (lapsed(t, slot_start[hit], swin)) begin
			slot_start[hit] = t;
			slot_count[hit] = 8'd0;
		end
		if (slot_count[hit] >= slim)
			return pswrl_pkg::ST_SOURCE;
		slot_count[hit] = slot_count[hit] + 8'd1;
		g_count = g_count + 8'd1;
		return pswrl_pkg::ST_ALLOWED;
	endfunction

	// one request beat; valid stays up after acceptance unless a gap is drawn
	task automatic offer_request(input logic [63:0] t, input logic [63:0] kh,
			input logic [63:0] kl, input logic typed, input pswrl_pkg::status_t want);
		pswrl_pkg::status_t got;
		verdict_t           v;
		in_valid <= 1'b1;
		now <= t;
		key_high <= kh;
		key_low <= kl;
		do @(posedge clk); while (!in_ready);
		got = judge_request(t, kh, kl);
		v.status = typed ? want : got;
		v.allowed = (v.status == pswrl_pkg::ST_ALLOWED);
		pending_verdicts.push_back(v);
		if (jitter_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic cfg_beat(input cfg_idx_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pswrl_pkg::CFG_GLOBAL_WINDOW: gwin = val;
			pswrl_pkg::CFG_GLOBAL_LIMIT:  glim = val[7:0];
			pswrl_pkg::CFG_SOURCE_WINDOW: swin = val;
			pswrl_pkg::CFG_SOURCE_LIMIT:  slim = val[7:0];
			default: ;
		endcase
	endtask

	task automatic program_limits(input phase_t p);
		cfg_beat(pswrl_pkg::CFG_GLOBAL_WINDOW, p.gw);
		cfg_beat(pswrl_pkg::CFG_GLOBAL_LIMIT, {24'd0, p.gl});
		cfg_beat(pswrl_pkg::CFG_SOURCE_WINDOW, p.sw);
		cfg_beat(pswrl_pkg::CFG_SOURCE_LIMIT, {24'd0, p.sl});
		// unmapped index, must leave every register alone
		cfg_beat(cfg_idx_t'($urandom_range(pswrl_pkg::CFG_SOURCE_LIMIT + 1,
			(1 << pswrl_pkg::CFG_IDX_W) - 1)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input phase_t p);
		int          n;
		int          k;
		int          roll;
		logic [63:0] kh;
		logic [63:0] kl;
		wait_quiet();
		program_limits(p);
		for (n = 0; n < POOL_MAX; n++) begin
			pool_hi[n] = {$urandom, $urandom};
			pool_lo[n] = {$urandom, $urandom};
		end
		jitter_on = p.jitter;
		if (p.squeeze)
			rx_hold = 1'b1;
		for (n = 0; n < p.items; n++) begin
			if (p.sweep) begin
				k = n % p.pool;
				t_cursor = t_cursor + 64'($urandom_range(0, p.step));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 80)
					t_cursor = t_cursor + 64'($urandom_range(0, p.step));
				else if (roll < 90)
					t_cursor = t_cursor - 64'($urandom_range(0, p.step));
				else if (roll < 95)
					t_cursor = {$urandom, $urandom};
				k = $urandom_range(0, p.pool - 1);
			end
			kh = pool_hi[k];
			kl = pool_lo[k];
			// stray keys now and then
			if (!p.sweep && $urandom_range(0, 9) == 0) begin
				kh = {$urandom, $urandom};
				kl = {$urandom, $urandom};
			end
			offer_request(t_cursor, kh, kl, 1'b0, pswrl_pkg::ST_ALLOWED);
		end
	endtask

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t unexpected result beat: allowed %0d status %0d",
					$time, allowed, status);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (allowed !== want.allowed) begin
					$display("%0t allowed mismatch: expected %0d actual %0d",
						$time, want.allowed, allowed);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t status mismatch: expected %0d actual %0d",
						$time, want.status, status);
					errors++;
				end
			end
		end
	end

	initial begin : receiver
		int n;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
				out_ready <= 1'b1;
			end else if (jitter_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 10);
				repeat (n) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[per_source_window_rate_limiter_unit] ERROR");
		$finish;
	end

	initial begin : stimulus
		int     r;
		int     i;
		phase_t closing;
		errors = 0;
		jitter_on = 1'b1;
		rx_hold = 1'b0;
		t_cursor = '0;
		gwin = pswrl_pkg::GLOBAL_WINDOW_RST;
		glim = pswrl_pkg::GLOBAL_LIMIT_RST;
		swin = pswrl_pkg::SOURCE_WINDOW_RST;
		slim = pswrl_pkg::SOURCE_LIMIT_RST;
		g_start = '0;
		g_count = '0;
		for (i = 0; i < pswrl_pkg::TABLE_ENTRIES; i++) begin
			slot_used[i] = 1'b0;
			slot_count[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < N_PROBES; r++)
			offer_request(probe_rows[r].t, probe_rows[r].kh, probe_rows[r].kl,
				probe_rows[r].typed, probe_rows[r].want);

		for (r = 0; r < N_PHASES; r++)
			run_phase(phase_plan[r]);

		// closing stretch: random settings, no idling on either side
		closing.gw = 32'($urandom_range(1, 3000));
		closing.gl = 8'($urandom_range(1, 40));
		closing.sw = 32'($urandom_range(1, 3000));
		closing.sl = 8'($urandom_range(1, 6));
		closing.items = 16'd60;
		closing.pool = 9'd10;
		closing.step = 32'd200;
		closing.sweep = 1'b0;
		closing.jitter = 1'b0;
		closing.squeeze = 1'b0;
		run_phase(closing);

		wait_quiet();
		repeat (pswrl_pkg::TABLE_ENTRIES + 4) @(posedge clk);
		if (errors == 0)
			$display("[per_source_window_rate_limiter_unit] OK");
		else
			$display("[per_source_window_rate_limiter_unit] ERROR");
		$finish;
	end

endmodule
